// ===== sv/idalloc_pkg.sv =====
`timescale 1ns / 1ps

package idalloc_pkg;

   localparam int ID_BITS = 8;
   localparam int ID_SPACE = 1 << ID_BITS;
   localparam int STACK_DEPTH = ID_SPACE - 1;
   localparam logic [ID_BITS-1:0] ID_MAX = ID_BITS'(ID_SPACE - 1);
   localparam logic [ID_BITS-1:0] ID_NONE = '0;

   typedef logic [ID_BITS-1:0] id_type;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DISABLED  = 3'd1,
      ST_EXHAUSTED = 3'd2,
      ST_ZERO_ID   = 3'd3,
      ST_NOT_ALLOC = 3'd4
   } status_type;

endpackage

// ===== sv/id_allocator_free_stack.sv =====
`timescale 1ns / 1ps

// Allocates nonzero ids and takes them back, one transaction per cycle while rsp_ready does
// not stall the output, through one input register and one result register. An allocate
// reuses the most recently freed id from a LIFO free stack held in a 255-entry RAM, and
// otherwise counts up to a fresh id until the id space is exhausted. A free is rejected for
// id zero and for any id not currently allocated, which catches double frees. Allocated
// marks live in flip-flops that reset clears at once, so there is no clearing pass. While
// the enable register is zero every request is answered with the disabled status and the
// state is left alone.
module id_allocator_free_stack (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_free_id,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_id,
   output logic [2:0] rsp_status,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_enable
);

   logic                         enable_ff;
   logic                         in_valid_ff;
   idalloc_pkg::action_type      in_action_ff;
   idalloc_pkg::id_type          in_free_id_ff;
   logic                         out_valid_ff;
   logic                         out_pop_ff;
   idalloc_pkg::id_type          out_id_ff;
   idalloc_pkg::status_type      out_status_ff;
   logic                         pop_pend_ff;
   idalloc_pkg::id_type          counter_ff;
   idalloc_pkg::id_type          counter_in;
   idalloc_pkg::id_type          count_ff;
   idalloc_pkg::id_type          count_in;
   logic [idalloc_pkg::ID_SPACE-1:0] mark_ff;
   logic [idalloc_pkg::ID_SPACE-1:0] mark_in;

   logic                         advance;
   logic                         mark_hit;
   logic                         do_pop;
   logic                         do_push;
   logic                         do_count;
   idalloc_pkg::id_type          fresh_id;
   idalloc_pkg::id_type          res_id;
   idalloc_pkg::status_type      res_status;
   idalloc_pkg::id_type          ram_rdata;
   logic                         ram_we;
   logic                         ram_re;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign fresh_id  = counter_ff + idalloc_pkg::ID_BITS'(1);

   // A pop from the previous cycle sets its mark only now, so it is forwarded here.
   assign mark_hit = mark_ff[in_free_id_ff] || (pop_pend_ff && (ram_rdata == in_free_id_ff));

   always_comb begin
      res_id     = idalloc_pkg::ID_NONE;
      res_status = idalloc_pkg::ST_OK;
      do_pop     = 1'b0;
      do_push    = 1'b0;
      do_count   = 1'b0;
      if (!enable_ff) begin
         res_status = idalloc_pkg::ST_DISABLED;
      end else if (in_action_ff == idalloc_pkg::ACT_ALLOC) begin
         if (count_ff != '0) begin
            do_pop = 1'b1;
         end else if (counter_ff == idalloc_pkg::ID_MAX) begin
            res_status = idalloc_pkg::ST_EXHAUSTED;
         end else begin
            do_count = 1'b1;
            res_id   = fresh_id;
         end
      end else begin
         if (in_free_id_ff == idalloc_pkg::ID_NONE) begin
            res_status = idalloc_pkg::ST_ZERO_ID;
         end else if (!mark_hit) begin
            res_status = idalloc_pkg::ST_NOT_ALLOC;
         end else begin
            do_push = 1'b1;
         end
      end
   end

   assign ram_re = advance && do_pop;
   assign ram_we = advance && do_push
                   && (count_ff != idalloc_pkg::ID_BITS'(idalloc_pkg::STACK_DEPTH));

   always_comb begin
      mark_in    = mark_ff;
      counter_in = counter_ff;
      count_in   = count_ff;
      if (pop_pend_ff) begin
         mark_in[ram_rdata] = 1'b1;
      end
      if (advance && do_count) begin
         mark_in[fresh_id] = 1'b1;
         counter_in        = fresh_id;
      end
      if (advance && do_push) begin
         mark_in[in_free_id_ff] = 1'b0;
      end
      if (ram_re) begin
         count_in = count_ff - idalloc_pkg::ID_BITS'(1);
      end else if (ram_we) begin
         count_in = count_ff + idalloc_pkg::ID_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pop_pend_ff  <= 1'b0;
         counter_ff   <= '0;
         count_ff     <= '0;
         mark_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_enable;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         pop_pend_ff <= ram_re;
         counter_ff  <= counter_in;
         count_ff    <= count_in;
         mark_ff     <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff  <= idalloc_pkg::action_type'(req_action);
         in_free_id_ff <= req_free_id;
      end
      if (advance) begin
         out_pop_ff    <= do_pop;
         out_id_ff     <= res_id;
         out_status_ff <= res_status;
      end
   end

   idalloc_ram #(
      .WIDTH(idalloc_pkg::ID_BITS),
      .DEPTH(idalloc_pkg::STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(count_ff),
      .wr_data(in_free_id_ff),
      .rd_en  (ram_re),
      .rd_addr(count_ff - idalloc_pkg::ID_BITS'(1)),
      .rd_data(ram_rdata)
   );

   assign rsp_valid  = out_valid_ff;
   assign rsp_id     = out_pop_ff ? ram_rdata : out_id_ff;
   assign rsp_status = out_status_ff;

endmodule

// ===== sv/idalloc_ram.sv =====
`timescale 1ns / 1ps

module idalloc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 255
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int RUN_LIMIT = 200000;
   localparam int HOLD_CYCLES = 60;
   localparam int HOLD_AFTER = 500;

   typedef struct {
      idalloc_pkg::action_type act;
      idalloc_pkg::id_type     fid;
   } request_type;

   typedef struct {
      idalloc_pkg::id_type     id;
      idalloc_pkg::status_type status;
   } grant_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_action = 1'b0;
   logic [7:0] req_free_id = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_id;
   logic [2:0] rsp_status;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_enable = 1'b0;

   request_type requests_pending[$];
   grant_type   grants_due[$];

   logic                grant_enable = 1'b1;
   idalloc_pkg::id_type next_id = idalloc_pkg::ID_NONE;
   idalloc_pkg::id_type free_ids[idalloc_pkg::STACK_DEPTH];
   int                  free_depth = 0;
   bit                  granted[idalloc_pkg::ID_SPACE];

   bit          quiet = 1'b0;
   int          failures = 0;
   int          rsp_count = 0;
   int          send_gap = 0;
   int          stall_left = 0;
   bit          hold_done = 1'b0;
   int          cycle_count = 0;
   request_type next_req;
   grant_type   due;
   grant_type   seen;

   id_allocator_free_stack dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_free_id(req_free_id),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_id     (rsp_id),
      .rsp_status (rsp_status),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_enable (csr_enable)
   );

   always #4 clock = ~clock;

   function automatic void predict_grant(input idalloc_pkg::action_type act,
                                         input idalloc_pkg::id_type fid,
                                         output idalloc_pkg::id_type rid,
                                         output idalloc_pkg::status_type st);
      rid = idalloc_pkg::ID_NONE;
      st = idalloc_pkg::ST_OK;
      if (!grant_enable) begin
         st = idalloc_pkg::ST_DISABLED;
      end else if (act == idalloc_pkg::ACT_ALLOC) begin
         if (free_depth > 0) begin
            free_depth--;
            rid = free_ids[free_depth];
            granted[rid] = 1'b1;
         end else if (next_id == idalloc_pkg::ID_MAX) begin
            st = idalloc_pkg::ST_EXHAUSTED;
         end else begin
            next_id = next_id + 8'd1;
            rid = next_id;
            granted[rid] = 1'b1;
         end
      end else if (fid == idalloc_pkg::ID_NONE) begin
         st = idalloc_pkg::ST_ZERO_ID;
      end else if (!granted[fid]) begin
         st = idalloc_pkg::ST_NOT_ALLOC;
      end else begin
         granted[fid] = 1'b0;
         if (free_depth < idalloc_pkg::STACK_DEPTH) begin
            free_ids[free_depth] = fid;
            free_depth++;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_grant(idalloc_pkg::action_type'(req_action), req_free_id,
                          due.id, due.status);
            grants_due.insert(grants_due.size(), due);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (requests_pending.size() > 0) begin
               next_req = requests_pending.pop_front();
               req_action <= next_req.act;
               req_free_id <= next_req.fid;
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(5) == 0) begin
                  send_gap = $urandom_range(1, 3);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (grants_due.size() == 0) begin
               $error("response transaction with nothing outstanding: id %0d status %0d",
                      rsp_id, rsp_status);
               failures++;
            end else begin
               seen = grants_due.pop_front();
               if (rsp_id !== seen.id) begin
                  $error("id mismatch: expected %0d, actual %0d", seen.id, rsp_id);
                  failures++;
               end
               if (rsp_status !== seen.status) begin
                  $error("status mismatch: expected %0d, actual %0d", seen.status, rsp_status);
                  failures++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && rsp_count >= HOLD_AFTER) begin
            hold_done = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic push_request(input idalloc_pkg::action_type act,
                               input idalloc_pkg::id_type fid);
      request_type r;
      r.act = act;
      r.fid = fid;
      requests_pending.insert(requests_pending.size(), r);
   endtask

   // Frees mostly target ids that are currently handed out so the free stack gets deep.
   task automatic push_random(input int count, input int alloc_pct);
      idalloc_pkg::id_type pick;
      repeat (count) begin
         while (requests_pending.size() >= 2) @(posedge clock);
         pick = idalloc_pkg::id_type'($urandom_range(255));
         if ($urandom_range(99) < alloc_pct) begin
            push_request(idalloc_pkg::ACT_ALLOC, pick);
         end else begin
            if ($urandom_range(7) != 0) begin
               for (int k = 0; k < 8 && !granted[pick]; k++) begin
                  pick = idalloc_pkg::id_type'($urandom_range(1, 255));
               end
            end
            push_request(idalloc_pkg::ACT_FREE, pick);
         end
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (requests_pending.size() != 0 || req_valid || grants_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_enable(input logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_enable <= value;
      do @(posedge clock);
      while (!csr_ready);
      grant_enable = value;
      csr_valid <= 1'b0;
   endtask

   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_enable(1'b1);

      push_request(idalloc_pkg::ACT_FREE, 8'd0);
      push_request(idalloc_pkg::ACT_FREE, 8'd1);
      push_request(idalloc_pkg::ACT_FREE, 8'd255);
      push_request(idalloc_pkg::ACT_ALLOC, 8'd0);
      push_request(idalloc_pkg::ACT_ALLOC, 8'd255);
      push_request(idalloc_pkg::ACT_ALLOC, 8'd170);
      push_request(idalloc_pkg::ACT_FREE, 8'd2);
      push_request(idalloc_pkg::ACT_FREE, 8'd2);
      push_request(idalloc_pkg::ACT_FREE, 8'd3);
      push_request(idalloc_pkg::ACT_ALLOC, 8'd85);
      push_request(idalloc_pkg::ACT_ALLOC, 8'd0);
      push_request(idalloc_pkg::ACT_ALLOC, 8'd0);
      push_request(idalloc_pkg::ACT_FREE, 8'd128);
      push_request(idalloc_pkg::ACT_FREE, 8'd4);
      push_request(idalloc_pkg::ACT_FREE, 8'd1);
      wait_idle();

      write_enable(1'b0);
      push_request(idalloc_pkg::ACT_ALLOC, 8'd0);
      push_request(idalloc_pkg::ACT_FREE, 8'd0);
      push_request(idalloc_pkg::ACT_FREE, 8'd2);
      push_request(idalloc_pkg::ACT_FREE, 8'd255);
      push_random(40, 50);
      wait_idle();
      write_enable(1'b1);

      push_random(350, 95);
      push_random(400, 45);
      wait_idle();

      write_enable(1'b0);
      push_random(30, 50);
      wait_idle();
      write_enable(1'b1);

      quiet = 1'b1;
      push_random(200, 50);
      wait_idle();
      repeat (8) @(posedge clock);

      if (failures == 0 && grants_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/idalloc_pkg.sv
sv/idalloc_ram.sv
sv/id_allocator_free_stack.sv
tb/testbench.sv
